// ----- src/pidr_pkg.sv -----
// Shared constants and arctangent table for the planar dead-reckoning block.
package pidr_pkg;

    localparam int ACC_WIDTH_DEF    = 64;
    localparam int ROTATE_STEPS_DEF = 16;
    localparam int MAX_ROT_STEPS    = 24;
    localparam int OUT_W            = 64;
    localparam int TS_W             = 32;
    localparam int ANG_W            = 16;
    localparam int ACCEL_W          = 16;
    localparam int CORDIC_W         = 27;
    localparam int WORLD_W          = 21;
    localparam int GAIN_W           = 18;
    localparam int ROUND_SHIFT      = 24;
    localparam int Z_W              = 32;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q16 = GAIN_W'(39797);

    // CORDIC arctangent per step, 2^32 = 2 pi
    function automatic logic [Z_W-1:0] atan_val(input logic [4:0] idx);
        logic [Z_W-1:0] r;
        begin
            case (idx)
                5'd0:  r = 32'd536870912;
                5'd1:  r = 32'd316933406;
                5'd2:  r = 32'd167458907;
                5'd3:  r = 32'd85004756;
                5'd4:  r = 32'd42667331;
                5'd5:  r = 32'd21354465;
                5'd6:  r = 32'd10680350;
                5'd7:  r = 32'd5340245;
                5'd8:  r = 32'd2670163;
                5'd9:  r = 32'd1335087;
                5'd10: r = 32'd667544;
                5'd11: r = 32'd333772;
                5'd12: r = 32'd166886;
                5'd13: r = 32'd83443;
                5'd14: r = 32'd41722;
                5'd15: r = 32'd20861;
                5'd16: r = 32'd10430;
                5'd17: r = 32'd5215;
                5'd18: r = 32'd2608;
                5'd19: r = 32'd1304;
                5'd20: r = 32'd652;
                5'd21: r = 32'd326;
                5'd22: r = 32'd163;
                5'd23: r = 32'd81;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- src/pidr_evt_if.sv -----
// Sensor event channel: valid/ready handshake with the event word.
interface pidr_evt_if;
    logic               valid;
    logic               ready;
    logic [31:0]        timestamp_us;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;

    modport source (output valid, output timestamp_us, output yaw_angle,
                    output accel_x, output accel_y, input ready);
    modport sink   (input valid, input timestamp_us, input yaw_angle,
                    input accel_x, input accel_y, output ready);
endinterface

// ----- src/pidr_res_if.sv -----
// Result channel: valid/ready handshake with the navigation state word.
interface pidr_res_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] vel_x;
    logic signed [63:0] vel_y;
    logic signed [63:0] pos_x;
    logic signed [63:0] pos_y;
    logic               integrated;

    modport source (output valid, output vel_x, output vel_y, output pos_x,
                    output pos_y, output integrated, input ready);
    modport sink   (input valid, input vel_x, input vel_y, input pos_x,
                    input pos_y, input integrated, output ready);
endinterface

// ----- src/planar_inertial_dead_reckoning.sv -----
// Top level: yaw rotation by CORDIC and semi-implicit Euler integration.
//
//  channel | dir | handshake     | word
//  evt     | in  | valid/ready   | timestamp_us, yaw_angle, accel_x, accel_y
//  res     | out | valid/ready   | vel_x, vel_y, pos_x, pos_y, integrated
//
// An integrated event runs its CORDIC rotation at one step per cycle, then
// two bit-serial dt multiplies (velocity, then position).
// An event with stored timestamp zero skips rotation and integration.
// Reset clears the timestamp and the four accumulators at once.
// A stalled result holds in the output register; the next event is taken
// once the sequencer is back in idle.
module planar_inertial_dead_reckoning #(
    parameter int ACC_WIDTH    = pidr_pkg::ACC_WIDTH_DEF,
    parameter int ROTATE_STEPS = pidr_pkg::ROTATE_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pidr_evt_if.sink    evt,
    pidr_res_if.source  res
);
    import pidr_pkg::*;

    localparam int W     = ACC_WIDTH;
    localparam int RC_W  = $clog2(ROTATE_STEPS);
    localparam int PX_W  = CORDIC_W + GAIN_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ROT    = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_VSTART = 3'd3;
    localparam logic [2:0] ST_VMUL   = 3'd4;
    localparam logic [2:0] ST_PMUL   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]                state_reg, state_next;
    logic [TS_W-1:0]           last_time_reg, last_time_next;
    logic [TS_W-1:0]           dt_reg, dt_next;
    logic                      integ_reg, integ_next;
    logic [RC_W-1:0]           rc_reg, rc_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [Z_W-1:0]            z_reg, z_next;
    logic signed [WORLD_W-1:0] wx_reg, wx_next, wy_reg, wy_next;
    logic signed [W-1:0]       vx_reg, vx_next, vy_reg, vy_next;
    logic signed [W-1:0]       px_reg, px_next, py_reg, py_next;

    logic                      res_valid_reg, res_valid_next;
    logic signed [OUT_W-1:0]   rvx_reg, rvy_reg, rpx_reg, rpy_reg;
    logic                      rint_reg;

    logic                      evt_acc;
    logic signed [CORDIC_W-1:0] ax0, ay0, dx, dy;
    logic [Z_W-1:0]            z0;
    logic signed [PX_W-1:0]    mx, my;
    logic                      mul_start;
    logic signed [W-1:0]       opx, opy, prx, pry;
    logic                      dnx, dny;
    logic signed [W-1:0]       addx, addy, basex, basey;
    logic                      out_free;

    // saturating add to W bits
    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        begin
            s = {a[W-1], a} + {b[W-1], b};
            if (s[W] != s[W-1])
                return s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            return s[W-1:0];
        end
    endfunction

    assign evt_acc   = evt.valid && evt.ready;
    assign evt.ready = (state_reg == ST_IDLE);
    assign out_free  = !res_valid_reg || res.ready;

    // CORDIC seed with half-turn fold
    assign z0  = {evt.yaw_angle, 16'b0};
    assign ax0 = CORDIC_W'(evt.accel_x) <<< 8;
    assign ay0 = CORDIC_W'(evt.accel_y) <<< 8;
    assign dx  = y_reg >>> rc_reg;
    assign dy  = x_reg >>> rc_reg;

    // gain correction
    assign mx = x_reg * $signed({1'b0, INV_GAIN_Q16[GAIN_W-2:0]});
    assign my = y_reg * $signed({1'b0, INV_GAIN_Q16[GAIN_W-2:0]});

    // multiplier operands: world accel, then updated velocity
    assign mul_start = (state_reg == ST_VSTART) ||
                       (state_reg == ST_VMUL && dnx);
    assign opx = (state_reg == ST_VSTART) ? W'(wx_reg) : vx_next;
    assign opy = (state_reg == ST_VSTART) ? W'(wy_reg) : vy_next;

    pidr_smul #(.W(W)) u_mul_x (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .opnd(opx),
        .dt(dt_reg), .done(dnx), .prod(prx)
    );
    pidr_smul #(.W(W)) u_mul_y (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .opnd(opy),
        .dt(dt_reg), .done(dny), .prod(pry)
    );

    assign basex = (state_reg == ST_VMUL) ? vx_reg : px_reg;
    assign basey = (state_reg == ST_VMUL) ? vy_reg : py_reg;
    assign addx  = sat_add(basex, prx);
    assign addy  = sat_add(basey, pry);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        last_time_next = last_time_reg;
        dt_next        = dt_reg;
        integ_next     = integ_reg;
        rc_next        = rc_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        res_valid_next = res_valid_reg && !res.ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_acc)
                begin
                    last_time_next = evt.timestamp_us;
                    dt_next        = evt.timestamp_us - last_time_reg;
                    rc_next        = '0;
                    if (z0[31] ^ z0[30])
                    begin
                        x_next = -ax0;
                        y_next = -ay0;
                        z_next = z0 + 32'h8000_0000;
                    end
                    else
                    begin
                        x_next = ax0;
                        y_next = ay0;
                        z_next = z0;
                    end
                    integ_next = (last_time_reg != '0);
                    state_next = (last_time_reg != '0) ? ST_ROT : ST_DONE;
                end
            end
            ST_ROT:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_val(5'(rc_reg));
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_val(5'(rc_reg));
                end
                rc_next = rc_reg + 1'b1;
                if (rc_reg == RC_W'(ROTATE_STEPS - 1))
                    state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                wx_next    = WORLD_W'((mx + (PX_W'(1) <<< (ROUND_SHIFT - 1)))
                                      >>> ROUND_SHIFT);
                wy_next    = WORLD_W'((my + (PX_W'(1) <<< (ROUND_SHIFT - 1)))
                                      >>> ROUND_SHIFT);
                state_next = ST_VSTART;
            end
            ST_VSTART:
            begin
                state_next = ST_VMUL;
            end
            ST_VMUL:
            begin
                if (dnx)
                begin
                    vx_next    = addx;
                    vy_next    = addy;
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                if (dnx)
                begin
                    px_next    = addx;
                    py_next    = addy;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_time_reg <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            vx_reg        <= vx_next;
            vy_reg        <= vy_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        integ_reg <= integ_next;
        rc_reg    <= rc_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        wx_reg    <= wx_next;
        wy_reg    <= wy_next;
        if (state_reg == ST_DONE && out_free)
        begin
            rvx_reg  <= OUT_W'(vx_reg);
            rvy_reg  <= OUT_W'(vy_reg);
            rpx_reg  <= OUT_W'(px_reg);
            rpy_reg  <= OUT_W'(py_reg);
            rint_reg <= integ_reg;
        end
    end

    // result word
    assign res.valid      = res_valid_reg;
    assign res.vel_x      = rvx_reg;
    assign res.vel_y      = rvy_reg;
    assign res.pos_x      = rpx_reg;
    assign res.pos_y      = rpy_reg;
    assign res.integrated = rint_reg;

`ifndef NO_ASSERTIONS
    // both lanes of the serial multiplier finish together
    a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
        dnx == dny)
        else $error("multiplier lanes out of step");

    // multiplier completion only seen in the integration states
    a_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        dnx |-> (state_reg == ST_VMUL || state_reg == ST_PMUL))
        else $error("multiplier done outside integration");

    // a first event goes straight to the result without integration
    a_first_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_acc && last_time_reg == '0) |=> (state_reg == ST_DONE && !integ_reg))
        else $error("first event was integrated");

    // velocity changes only when a velocity multiply completes
    a_vel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_VMUL && dnx) |=> $stable(vx_reg))
        else $error("velocity changed outside update");
`endif

endmodule

// ----- src/pidr_smul.sv -----
// Bit-serial saturating multiply of a signed accumulator value by dt.
module pidr_smul #(
    parameter int W = pidr_pkg::ACC_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [W-1:0]        opnd,
    input  logic [pidr_pkg::TS_W-1:0]  dt,
    output logic                       done,
    output logic signed [W-1:0]        prod
);
    import pidr_pkg::*;

    localparam int CNT_W = $clog2(TS_W);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic [W-1:0]     mag_reg, mag_next;
    logic [TS_W-1:0]  dts_reg, dts_next;
    logic [W+1:0]     acc_reg, acc_next;
    logic             sticky_reg, sticky_next;
    logic [W-1:0]     lim;
    logic [W+1:0]     step_sum;

    // magnitude limit differs by sign
    assign lim = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    // MSB-first shift-add: acc = 2*acc + bit*mag
    assign step_sum = {acc_reg[W:0], 1'b0}
                    + (dts_reg[TS_W-1] ? {2'b00, mag_reg} : '0);

    always_comb
    begin
        run_next    = run_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        dts_next    = dts_reg;
        acc_next    = acc_reg;
        sticky_next = sticky_reg;
        if (start)
        begin
            run_next    = 1'b1;
            cnt_next    = '0;
            neg_next    = opnd[W-1];
            mag_next    = opnd[W-1] ? W'(-opnd) : W'(opnd);
            dts_next    = dt;
            acc_next    = '0;
            sticky_next = 1'b0;
        end
        else if (run_reg)
        begin
            dts_next = {dts_reg[TS_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (!sticky_reg)
            begin
                acc_next = step_sum;
                if (step_sum > {2'b00, lim})
                    sticky_next = 1'b1;
            end
            if (cnt_reg == CNT_W'(TS_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        dts_reg    <= dts_next;
        acc_reg    <= acc_next;
        sticky_reg <= sticky_next;
    end

    // saturate or apply sign
    always_comb
    begin
        if (sticky_reg)
            prod = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else if (neg_reg)
            prod = W'(-acc_reg[W-1:0]);
        else
            prod = acc_reg[W-1:0];
    end

    assign done = done_reg;

endmodule

// ----- test/pidr_nav_checker.sv -----
// Checker for the dead-reckoning block: predicts each result word and compares it.
`timescale 1ns / 1ps

module pidr_nav_checker (
    input  logic clk,
    input  logic rst_n,
    pidr_evt_if  evt,
    pidr_res_if  res,
    output int   errors,
    output int   pending
);
    import pidr_pkg::*;

    typedef struct packed {
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic               integrated;
    } nav_word_t;

    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

    // arctangent per rotation step, full circle = 2^32
    localparam logic [31:0] ATAN_STEP [MAX_ROT_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680350, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    // navigation state as the block should hold it
    logic [31:0] nav_last_ts;
    longint      nav_vx, nav_vy, nav_px, nav_py;
    nav_word_t   nav_expected[$];

    function automatic longint clamp_acc(logic signed [129:0] v);
        if (v > ACC_HI)
            return ACC_HI;
        if (v < ACC_LO)
            return ACC_LO;
        return longint'(v);
    endfunction

    function automatic longint scale_dt(longint v, logic [31:0] dt);
        logic signed [129:0] p;
        p = 130'(v) * $signed({98'd0, dt});
        return clamp_acc(p);
    endfunction

    function automatic longint acc_sum(longint a, longint b);
        return clamp_acc(130'(a) + 130'(b));
    endfunction

    // body to world rotation: CORDIC with gain correction and rounding
    task automatic to_world(input logic signed [15:0] ax, input logic signed [15:0] ay,
                            input logic signed [15:0] yaw, output longint wx,
                            output longint wy);
        longint      x, y, dx, dy;
        logic [31:0] z;
        x = longint'(ax) * 256;
        y = longint'(ay) * 256;
        z = {yaw, 16'h0000};
        if (z >= 32'h4000_0000 && z < 32'hC000_0000)
        begin
            x = -x;
            y = -y;
            z = z + 32'h8000_0000;
        end
        for (int i = 0; i < ROTATE_STEPS_DEF; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (!z[31])
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_STEP[i];
            end
        end
        wx = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
        wy = (y * 39797 + (64'sd1 <<< 23)) >>> 24;
    endtask

    // advance the navigation state by one event, queue the result word
    task automatic integrate_event(input logic [31:0] ts, input logic signed [15:0] yaw,
                                   input logic signed [15:0] ax,
                                   input logic signed [15:0] ay);
        nav_word_t   w;
        logic [31:0] dt;
        longint      wx, wy;
        w.integrated = 1'b0;
        if (nav_last_ts != 32'd0)
        begin
            dt = ts - nav_last_ts;
            to_world(ax, ay, yaw, wx, wy);
            nav_vx = acc_sum(nav_vx, scale_dt(wx, dt));
            nav_vy = acc_sum(nav_vy, scale_dt(wy, dt));
            nav_px = acc_sum(nav_px, scale_dt(nav_vx, dt));
            nav_py = acc_sum(nav_py, scale_dt(nav_vy, dt));
            w.integrated = 1'b1;
        end
        nav_last_ts = ts;
        w.vel_x = nav_vx;
        w.vel_y = nav_vy;
        w.pos_x = nav_px;
        w.pos_y = nav_py;
        nav_expected.push_back(w);
    endtask

    // watch both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        nav_word_t want, got;
        if (!rst_n)
        begin
            nav_last_ts = '0;
            nav_vx = 0;
            nav_vy = 0;
            nav_px = 0;
            nav_py = 0;
            nav_expected.delete();
            errors = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = '{res.vel_x, res.vel_y, res.pos_x, res.pos_y, res.integrated};
                if (nav_expected.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result word with none expected: %p", $realtime, got);
                end
                else
                begin
                    want = nav_expected.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (evt.valid && evt.ready)
                integrate_event(evt.timestamp_us, evt.yaw_angle, evt.accel_x, evt.accel_y);
        end
        pending = nav_expected.size();
    end
endmodule

// ----- test/tb_planar_inertial_dead_reckoning.sv -----
// Testbench top: clock, reset, event stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_planar_inertial_dead_reckoning;
    localparam int RANDOM_EVENTS = 1939;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles = 0;
    int   sent;
    int   burst_left;
    logic [31:0] cur_ts;

    pidr_evt_if evt ();
    pidr_res_if res ();

    planar_inertial_dead_reckoning u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt.sink),
        .res   (res.source)
    );

    pidr_nav_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .res     (res),
        .errors  (errors),
        .pending (pending)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one event word and hold it until taken
    task automatic send_word(input logic [31:0] ts, input logic [15:0] yaw,
                             input logic [15:0] ax, input logic [15:0] ay);
        @(negedge clk);
        evt.valid        <= 1'b1;
        evt.timestamp_us <= ts;
        evt.yaw_angle    <= yaw;
        evt.accel_x      <= ax;
        evt.accel_y      <= ay;
        do
            @(posedge clk);
        while (!evt.ready);
        sent++;
        cur_ts = ts;
    endtask

    task automatic pause_sender(input int n);
        @(negedge clk);
        evt.valid <= 1'b0;
        repeat (n)
            @(negedge clk);
    endtask

    // bursts of random length with random gaps
    task automatic send_paced(input logic [31:0] ts, input logic [15:0] yaw,
                              input logic [15:0] ax, input logic [15:0] ay);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 150));
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_word(ts, yaw, ax, ay);
    endtask

    // receiver: own stall pattern, one long hold-off
    initial
    begin
        int phase;
        res.ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            phase++;
            @(negedge clk);
            if (phase == 30)
            begin
                res.ready <= 1'b0;
                repeat (600)
                    @(negedge clk);
            end
            else if (phase % 9 == 0)
            begin
                res.ready <= 1'b1;
                repeat ($urandom_range(200, 800))
                    @(negedge clk);
            end
            else
            begin
                res.ready <= 1'b1;
                repeat ($urandom_range(1, 40))
                    @(negedge clk);
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 200))
                    @(negedge clk);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        logic [31:0] ts;
        int          pick;
        sent             = 0;
        burst_left       = 0;
        cur_ts           = '0;
        evt.valid        = 1'b0;
        evt.timestamp_us = '0;
        evt.yaw_angle    = '0;
        evt.accel_x      = '0;
        evt.accel_y      = '0;
        rst_n            = 1'b0;
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        // directed: stored-zero cases, then field extremes and quadrant edges
        send_word(32'd0, 16'h7FFF, 16'h7FFF, 16'h8000);
        send_word(32'd0, 16'h8000, 16'h8000, 16'h7FFF);
        send_word($urandom, 16'h0000, 16'h0100, 16'h0000);
        send_word(cur_ts, 16'h0000, 16'h0100, 16'h0000);
        send_word(cur_ts + 32'd1, 16'h0000, 16'h7FFF, 16'h7FFF);
        send_word(cur_ts + 32'd1000, 16'h4000, 16'h8000, 16'h8000);
        send_word(cur_ts + 32'd1000, 16'hC000, 16'h7FFF, 16'h8000);
        send_word(cur_ts + 32'd500, 16'h3FFF, 16'h1234, 16'hEDCC);
        send_word(cur_ts + 32'd500, 16'hBFFF, 16'h8000, 16'h0001);
        send_word(cur_ts + 32'd250, 16'h8000, 16'h0001, 16'hFFFF);
        send_word(cur_ts + 32'd250, 16'h7FFF, 16'hFFFF, 16'h0000);
        send_word(cur_ts - 32'd100, 16'h2000, 16'h0000, 16'h7FFF);
        send_word(cur_ts + 32'd300, 16'hE000, 16'h0000, 16'h0000);
        send_word(cur_ts + 32'd700, 16'hFFFF, 16'h8000, 16'h7FFF);

        // random events, mostly small forward steps
        while (sent < RANDOM_EVENTS)
        begin
            if (sent == 1000)
            begin
                pause_sender(1);
                while (pending != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                ts = cur_ts;
            else if (pick < 7)
                ts = cur_ts - $urandom_range(1, 2000);
            else
                ts = cur_ts + $urandom_range(1, 2000);
            send_paced(ts, 16'($urandom), 16'($urandom), 16'($urandom));
        end

        // tail: huge wrapped steps drive the positions into both rails
        send_paced(cur_ts + 32'hF000_0000, 16'h0000, 16'h7FFF, 16'h8000);
        repeat (6)
            send_paced($urandom, 16'h0000, 16'h7FFF, 16'h8000);
        send_paced(32'hFFFF_FFFF, 16'h0000, 16'h7FFF, 16'h8000);
        send_paced(32'd0, 16'h0000, 16'h8000, 16'h7FFF);
        send_paced(32'hFFFF_FFFF, 16'h4000, 16'h7FFF, 16'h7FFF);
        send_paced($urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        pause_sender(1);

        while (pending != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
